// File: sv/sgrm_pkg.sv
// shared types and constants for the sgr mouse report parser
// no dependencies; used by sgrm_core and sgr_mouse_escape_parser
`default_nettype none

package sgrm_pkg;

  // parser modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE     = 8'b0000_0001,
    MODE_ESC      = 8'b0000_0010,
    MODE_CSI      = 8'b0000_0100,
    MODE_BTN      = 8'b0000_1000,
    MODE_COL      = 8'b0001_0000,
    MODE_ROW      = 8'b0010_0000,
    MODE_CSI_SKIP = 8'b0100_0000,
    MODE_ESC_SKIP = 8'b1000_0000
  } mode_t;

  localparam logic [1:0] EV_EXIT    = 2'd0;
  localparam logic [1:0] EV_DRAG    = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_PRESS    = 8'h4D;
  localparam logic [7:0] CH_RELEASE  = 8'h6D;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;
  localparam logic [7:0] ESC_FINAL_HI = 8'h7F;

  localparam int unsigned BTN_LEFT = 0;
  localparam int unsigned BTN_DRAG = 32;

  typedef struct packed {
    logic               valid;
    logic [1:0]         code;
    logic [15:0]        x;
    logic [15:0]        y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } result_t;

endpackage

`default_nettype wire

// File: sv/sgrm_core.sv
// parser state machine, field accumulators and drag tracking
// depends on sgrm_pkg; processes one byte whenever step is high
`default_nettype none

module sgrm_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data,
  output sgrm_pkg::result_t      res
);

  sgrm_pkg::mode_t         mode, mode_next;
  logic [COORD_BITS-1:0]   button_acc, button_acc_next;
  logic [COORD_BITS-1:0]   col_acc, col_acc_next;
  logic [COORD_BITS-1:0]   row_acc, row_acc_next;
  logic                    drag_active, drag_active_next;
  logic [COORD_BITS-1:0]   last_col, last_col_next;
  logic [COORD_BITS-1:0]   last_row, last_row_next;

  logic                    is_digit, csi_final, esc_final;
  logic [COORD_BITS-1:0]   acc_sel, acc_new;
  logic [COORD_BITS+3:0]   acc_wide;
  logic [COORD_BITS+15:0]  col_ext, row_ext;
  logic [COORD_BITS+16:0]  dcol, drow;

  assign is_digit  = (data >= sgrm_pkg::CH_ZERO) && (data <= sgrm_pkg::CH_NINE);
  assign csi_final = (data >= sgrm_pkg::FINAL_LO) && (data <= sgrm_pkg::CSI_FINAL_HI);
  assign esc_final = (data >= sgrm_pkg::FINAL_LO) && (data <= sgrm_pkg::ESC_FINAL_HI);

  // acc * 10 + digit, saturating
  always_comb begin
    case (mode)
      sgrm_pkg::MODE_COL: acc_sel = col_acc;
      sgrm_pkg::MODE_ROW: acc_sel = row_acc;
      default:            acc_sel = button_acc;
    endcase
  end

  assign acc_wide = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                  + {{COORD_BITS{1'b0}}, data[3:0]};
  assign acc_new  = (acc_wide[COORD_BITS+3:COORD_BITS] != 4'd0) ?
                    {COORD_BITS{1'b1}} : acc_wide[COORD_BITS-1:0];

  assign col_ext = {16'd0, col_acc};
  assign row_ext = {16'd0, row_acc};
  assign dcol    = {17'd0, col_acc} - {17'd0, last_col};
  assign drow    = {17'd0, row_acc} - {17'd0, last_row};

  always_comb begin
    mode_next        = mode;
    button_acc_next  = button_acc;
    col_acc_next     = col_acc;
    row_acc_next     = row_acc;
    drag_active_next = drag_active;
    last_col_next    = last_col;
    last_row_next    = last_row;
    res.valid        = 1'b0;
    res.code         = sgrm_pkg::EV_EXIT;
    res.x            = col_ext[15:0];
    res.y            = row_ext[15:0];
    res.dx           = '0;
    res.dy           = '0;

    case (mode)
      sgrm_pkg::MODE_IDLE: begin
        if (data == sgrm_pkg::CH_ESC) begin
          mode_next = sgrm_pkg::MODE_ESC;
        end else begin
          res.valid = 1'b1;
          res.x     = '0;
          res.y     = '0;
        end
      end
      sgrm_pkg::MODE_ESC: begin
        if (data == sgrm_pkg::CH_LBRACKET) mode_next = sgrm_pkg::MODE_CSI;
        else if (esc_final)                mode_next = sgrm_pkg::MODE_IDLE;
        else                               mode_next = sgrm_pkg::MODE_ESC_SKIP;
      end
      sgrm_pkg::MODE_CSI: begin
        if (data == sgrm_pkg::CH_LT) begin
          button_acc_next = '0;
          col_acc_next    = '0;
          row_acc_next    = '0;
          mode_next       = sgrm_pkg::MODE_BTN;
        end else if (csi_final) begin
          mode_next = sgrm_pkg::MODE_IDLE;
        end else begin
          mode_next = sgrm_pkg::MODE_CSI_SKIP;
        end
      end
      sgrm_pkg::MODE_BTN, sgrm_pkg::MODE_COL, sgrm_pkg::MODE_ROW: begin
        if (is_digit) begin
          if (mode == sgrm_pkg::MODE_BTN)      button_acc_next = acc_new;
          else if (mode == sgrm_pkg::MODE_COL) col_acc_next    = acc_new;
          else                                 row_acc_next    = acc_new;
        end else if (data == sgrm_pkg::CH_SEMI && mode == sgrm_pkg::MODE_BTN) begin
          mode_next = sgrm_pkg::MODE_COL;
        end else if (data == sgrm_pkg::CH_SEMI && mode == sgrm_pkg::MODE_COL) begin
          mode_next = sgrm_pkg::MODE_ROW;
        end else begin
          // report closed by this byte
          mode_next = sgrm_pkg::MODE_IDLE;
          if (button_acc == COORD_BITS'(sgrm_pkg::BTN_LEFT)
              && data == sgrm_pkg::CH_PRESS) begin
            drag_active_next = 1'b1;
            last_col_next    = col_acc;
            last_row_next    = row_acc;
          end else if (button_acc == COORD_BITS'(sgrm_pkg::BTN_DRAG)
                       && data == sgrm_pkg::CH_PRESS && drag_active) begin
            last_col_next = col_acc;
            last_row_next = row_acc;
            res.valid     = 1'b1;
            res.code      = sgrm_pkg::EV_DRAG;
            res.dx        = dcol[16:0];
            res.dy        = drow[16:0];
          end else if (button_acc == COORD_BITS'(sgrm_pkg::BTN_LEFT)
                       && data == sgrm_pkg::CH_RELEASE) begin
            drag_active_next = 1'b0;
            res.valid        = 1'b1;
            res.code         = sgrm_pkg::EV_RELEASE;
          end
        end
      end
      sgrm_pkg::MODE_CSI_SKIP: begin
        if (csi_final) mode_next = sgrm_pkg::MODE_IDLE;
      end
      default: begin
        if (esc_final) mode_next = sgrm_pkg::MODE_IDLE;
      end
    endcase

    res.valid = res.valid & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sgrm_pkg::MODE_IDLE;
      button_acc  <= '0;
      col_acc     <= '0;
      row_acc     <= '0;
      drag_active <= 1'b0;
      last_col    <= '0;
      last_row    <= '0;
    end else if (step) begin
      mode        <= mode_next;
      button_acc  <= button_acc_next;
      col_acc     <= col_acc_next;
      row_acc     <= row_acc_next;
      drag_active <= drag_active_next;
      last_col    <= last_col_next;
      last_row    <= last_row_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/sgr_mouse_escape_parser.sv
// top level of the sgr mouse report parser: input register, parser core, result register
// depends on sgrm_pkg and sgrm_core
`default_nettype none

// Takes one terminal byte per transaction and reports exit keys, mouse drags and
// mouse releases decoded from ESC [ < b ; x ; y M/m reports. One byte is taken
// every clock cycle while in_stall is low; a byte passes an input register and
// the parser, and its event, if any, is loaded into the result register, from
// which it can be taken.
// in_stall rises only while a finished event waits in the result register with
// out_stall high and the held byte is ready to be parsed. Coordinates saturate
// at 2^COORD_BITS - 1 and are reported in their low 16 bits.

module sgr_mouse_escape_parser #(
  parameter int COORD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         in_byte,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [1:0]         event_code,
  output      logic [15:0]        pos_x,
  output      logic [15:0]        pos_y,
  output      logic signed [16:0] delta_x,
  output      logic signed [16:0] delta_y
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              step;
  sgrm_pkg::result_t res;

  // parse the held byte when the result register is free or being emptied
  assign step     = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
  end

  sgrm_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (held_byte),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      event_code <= res.code;
      pos_x      <= res.x;
      pos_y      <= res.y;
      delta_x    <= res.dx;
      delta_y    <= res.dy;
    end
  end

endmodule

`default_nettype wire
